>>> hdl/nlms_pkg.sv
package nlms_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned TapW    = 18;
  localparam int unsigned OutW    = 20;
  localparam int unsigned EsqW    = 39;
  localparam int unsigned StepW   = 18;
  localparam int unsigned RegW    = 20;
  localparam int unsigned NTapsW  = 7;
  localparam int unsigned CfgW    = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TapIdxW = 6;

  // accumulator, energy and numerator widths
  localparam int unsigned AccW = 48;
  localparam int unsigned DenW = 48;
  localparam int unsigned NumW = 56;

  localparam logic [CfgIdxW-1:0] CfgStepSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRegular  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTapsUsed = 2'd2;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSample = 1'b1;

  localparam logic [StepW-1:0]  StepReset = 18'd65536;
  localparam logic [RegW-1:0]   RegReset  = 20'd1074;
  localparam logic [NTapsW-1:0] TapsReset = 7'd64;

  localparam logic signed [OutW-1:0] OutMax = 20'sd524287;
  localparam logic signed [OutW-1:0] OutMin = -20'sd524288;
  localparam logic signed [TapW-1:0] TapMax = 18'sd131071;
  localparam logic signed [TapW-1:0] TapMin = -18'sd131072;

  // round half up to q.15 then saturate to the output range
  function automatic logic signed [OutW-1:0] round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] r;
    logic signed [AccW-1:0] s;
    r = acc + AccW'(1 << 15);
    s = r >>> 16;
    if (s > AccW'(OutMax)) return OutMax;
    if (s < AccW'(OutMin)) return OutMin;
    return s[OutW-1:0];
  endfunction

endpackage

>>> hdl/nlms_system_identification_core.sv
// nlms system identification core
//
// input stream s_axis: one transfer is a load item (tuser = 0, writes one
// reference tap) or a sample item (tuser = 1). a sample item yields one
// transfer on m_axis with y, d, e and e squared; a load item yields none.
// configuration: cfg_we_i writes step_size (0), regularization (1) or
// taps_in_use (2); the user must write only while the block is idle; the block does not enforce it.
//
// one item at a time. a load leaves the block idle, so the next item can
// be taken in the cycle after it. a sample shifts the whole delay line
// (read then write back each entry), forms both dot products and the
// energy over the n active taps, then updates each active tap: read,
// multiply, a restoring divide of the 56-bit numerator and write back.
// m_axis_tvalid and s_axis_tready rise in the same cycle; most of the
// time per sample goes into the per-tap divide. with a zero denominator
// the update is skipped.
// after reset the three memories are cleared by a sweep over all MAX_TAPS
// entries during which s_axis_tready stays low.
// when m_axis stalls the result is held in its output register; the next
// item is accepted but its result waits for that register to drain.
module nlms_system_identification_core #(
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [nlms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [nlms_pkg::CfgW-1:0]    cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] sample_in, [21:16] tap_index, [39:22] tap_value, [39:0] padded
  input  logic [39:0] s_axis_tdata,
  // [0] opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [19:0] filter_out, [39:20] reference_out, [59:40] error_out,
  // [98:60] error_squared, [103:99] zero
  output logic [103:0] m_axis_tdata
);

  localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned AccW = nlms_pkg::AccW;
  localparam int unsigned DenW = nlms_pkg::DenW;
  localparam int unsigned NumW = nlms_pkg::NumW;
  localparam int unsigned SW = nlms_pkg::SampleW;
  localparam int unsigned TW = nlms_pkg::TapW;
  localparam int unsigned OW = nlms_pkg::OutW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SHIFT, ST_SHWR, ST_DOT, ST_DOTLAST, ST_ERR,
    ST_UPRD, ST_MUL, ST_DIV, ST_WRITE, ST_OUT
  } state_e;

  state_e state_q;

  // memories
  logic signed [SW-1:0] xmem [MAX_TAPS];
  logic signed [TW-1:0] wmem [MAX_TAPS];
  logic signed [TW-1:0] rmem [MAX_TAPS];
  logic signed [SW-1:0] x_rd_q;
  logic signed [TW-1:0] w_rd_q, r_rd_q;

  logic [nlms_pkg::StepW-1:0]  step_q;
  logic [nlms_pkg::RegW-1:0]   reg_q;
  logic [nlms_pkg::NTapsW-1:0] ntaps_q;

  logic [CW-1:0] n_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] raddr_q;
  logic signed [SW-1:0] carry_q;
  logic signed [AccW-1:0] dacc_q, yacc_q;
  logic [DenW-1:0] den_q;
  logic signed [OW-1:0] y_q, d_q, e_q;
  logic signed [AccW-1:0] me_q;
  logic [NumW-1:0] mag_q, rem_q;
  logic neg_q;
  logic [6:0] bit_q;
  logic [NumW-1:0] quo_q;
  logic out_busy_q;
  logic [103:0] out_q;

  logic [CW-1:0] n_eff;
  always_comb begin
    n_eff = (ntaps_q == '0) ? CW'(1) :
            ((32'(ntaps_q) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(ntaps_q));
  end

  // products of the current tap for the dot products and the energy
  logic signed [SW+TW-1:0] xr_prod, xw_prod;
  logic signed [2*SW-1:0]  xx_prod;
  always_comb begin
    xr_prod = x_rd_q * r_rd_q;
    xw_prod = x_rd_q * w_rd_q;
    xx_prod = x_rd_q * x_rd_q;
  end

  // divider step: shift in one numerator bit, subtract if it fits
  logic [NumW:0] trial;
  logic [NumW-1:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[NumW-2:0], mag_q[bit_q[5:0]]};
    trial  = {1'b0, rem_sh} - {{(NumW+1-DenW){1'b0}}, den_q};
  end

  // rounding and saturating update of the current tap
  logic [NumW-1:0] qround;
  logic signed [TW+1:0] wnew;
  logic signed [TW-1:0] wsat;
  always_comb begin
    // round to nearest: remainder*2 >= den
    qround = quo_q + NumW'({rem_q, 1'b0} >= {{(NumW+1-DenW){1'b0}}, den_q});
    // any step of 2^18 or more saturates the tap anyway
    if (qround > NumW'(1 << TW)) begin
      wnew = neg_q ? -(TW+2)'(1 << TW) : (TW+2)'(1 << TW);
    end else begin
      wnew = neg_q ? (TW+2)'(w_rd_q) - (TW+2)'(qround)
                   : (TW+2)'(w_rd_q) + (TW+2)'(qround);
    end
    if (wnew > (TW+2)'(nlms_pkg::TapMax)) wsat = nlms_pkg::TapMax;
    else if (wnew < (TW+2)'(nlms_pkg::TapMin)) wsat = nlms_pkg::TapMin;
    else wsat = wnew[TW-1:0];
  end

  logic signed [AccW-1:0] eacc;
  logic signed [OW-1:0] e_sat;
  logic signed [2*OW-1:0] e_sq;
  always_comb begin
    eacc  = dacc_q - yacc_q;
    e_sat = nlms_pkg::round_sat(eacc);
    e_sq  = e_q * e_q;
  end

  logic signed [AccW+SW-1:0] num_full;
  always_comb num_full = me_q * (AccW+SW)'(x_rd_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_busy_q;
  assign m_axis_tdata  = out_q;

  // memory reads, one address per cycle
  always_ff @(posedge clk_i) begin
    x_rd_q <= xmem[raddr_q];
    w_rd_q <= wmem[raddr_q];
    r_rd_q <= rmem[raddr_q];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= nlms_pkg::StepReset;
      reg_q   <= nlms_pkg::RegReset;
      ntaps_q <= nlms_pkg::TapsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nlms_pkg::CfgStepSize: step_q  <= cfg_data_i[nlms_pkg::StepW-1:0];
        nlms_pkg::CfgRegular:  reg_q   <= cfg_data_i[nlms_pkg::RegW-1:0];
        nlms_pkg::CfgTapsUsed: ntaps_q <= cfg_data_i[nlms_pkg::NTapsW-1:0];
        default: ;
      endcase
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      xmem[cnt_q[AW-1:0]] <= '0;
      wmem[cnt_q[AW-1:0]] <= '0;
      rmem[cnt_q[AW-1:0]] <= '0;
    end else if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tuser == nlms_pkg::OpLoad) begin
      if (32'(s_axis_tdata[21:16]) < MAX_TAPS)
        rmem[AW'(s_axis_tdata[21:16])] <= s_axis_tdata[39:22];
    end else if (state_q == ST_SHWR) begin
      xmem[cnt_q[AW-1:0]] <= carry_q;
    end else if (state_q == ST_WRITE) begin
      wmem[cnt_q[AW-1:0]] <= wsat;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      out_busy_q <= 1'b0;
      raddr_q    <= '0;
    end else begin
      // output register: filled from the final state, cleared once taken
      if (state_q == ST_OUT && (!out_busy_q || m_axis_tready)) out_busy_q <= 1'b1;
      else if (m_axis_tready) out_busy_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(MAX_TAPS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tuser == nlms_pkg::OpSample) begin
            carry_q <= s_axis_tdata[SW-1:0];
            n_q     <= n_eff;
            cnt_q   <= '0;
            raddr_q <= '0;
            state_q <= ST_SHIFT;
          end
        end
        // whole delay line shifts: read old entry, write the carried one
        ST_SHIFT: state_q <= ST_SHWR;
        ST_SHWR: begin
          carry_q <= x_rd_q;
          if (cnt_q == CW'(MAX_TAPS - 1)) begin
            cnt_q   <= '0;
            raddr_q <= '0;
            dacc_q  <= '0;
            yacc_q  <= '0;
            den_q   <= DenW'(reg_q);
            state_q <= ST_DOT;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            raddr_q <= AW'(cnt_q + 1'b1);
            state_q <= ST_SHIFT;
          end
        end
        // one tap per cycle, each read issued in the cycle before its tap is summed
        ST_DOT: begin
          if (cnt_q != '0) begin
            dacc_q <= dacc_q + AccW'(xr_prod);
            yacc_q <= yacc_q + AccW'(xw_prod);
            den_q  <= den_q + DenW'($unsigned(xx_prod));
          end
          if (cnt_q == n_q) begin
            state_q <= ST_ERR;
          end else begin
            raddr_q <= AW'(cnt_q + 1'b1);
          end
          cnt_q <= cnt_q + 1'b1;
        end
        ST_ERR: begin
          y_q  <= nlms_pkg::round_sat(yacc_q);
          d_q  <= nlms_pkg::round_sat(dacc_q);
          e_q  <= e_sat;
          me_q <= AccW'($signed({1'b0, step_q})) * AccW'(e_sat);
          cnt_q <= '0;
          if (den_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            raddr_q <= '0;
            state_q <= ST_UPRD;
          end
        end
        ST_UPRD: state_q <= ST_MUL;
        ST_MUL: begin
          neg_q   <= num_full[AccW+SW-1];
          mag_q   <= num_full[AccW+SW-1] ? NumW'(-num_full) : NumW'(num_full);
          rem_q   <= '0;
          quo_q   <= '0;
          bit_q   <= 7'(NumW - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (!trial[NumW]) begin
            rem_q <= trial[NumW-1:0];
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          if (bit_q == '0) state_q <= ST_WRITE;
          bit_q <= bit_q - 1'b1;
        end
        ST_WRITE: begin
          if (cnt_q + 1'b1 == n_q) begin
            state_q <= ST_OUT;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            raddr_q <= AW'(cnt_q + 1'b1);
            state_q <= ST_UPRD;
          end
        end
        ST_OUT: begin
          if (!out_busy_q || m_axis_tready) begin
            out_q <= {5'd0, e_sq[nlms_pkg::EsqW-1:0], e_q, d_q, y_q};
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
